/* src/incremental_bipartite_matching_top_defines.svh */
// assertion macros used by the checker file
`ifndef INCREMENTAL_BIPARTITE_MATCHING_TOP_DEFINES_SVH
`define INCREMENTAL_BIPARTITE_MATCHING_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define IBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ibm check failed");

// next-cycle implication, off during reset
`define IBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ibm check failed");

`endif

/* src/ibm_pkg.sv */
// ----------------------------------------------------------------------------
// ibm_pkg
// Shared sizes, configuration bundle and sequencer states of the matcher.
// ----------------------------------------------------------------------------
package ibm_pkg;

	localparam int MAX_LEFT  = 256;
	localparam int MAX_RIGHT = 256;

	// fixed field widths
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	// derived node widths
	localparam int LW   = (MAX_LEFT > 1) ? $clog2(MAX_LEFT) : 1;
	localparam int RW   = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
	localparam int NIW  = (LW > RW) ? LW : RW;
	localparam int NMAX = (MAX_LEFT > MAX_RIGHT) ? MAX_LEFT : MAX_RIGHT;

	// search queue
	localparam int QDEPTH = MAX_LEFT + MAX_RIGHT;
	localparam int QAW    = $clog2(QDEPTH);

	// register file
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_NUM_LEFT  = 1'b0;
	localparam logic [0:0] REG_NUM_RIGHT = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CNT_W-1:0] LEFT_SAT  = CNT_W'(MAX_LEFT);
	localparam logic [CNT_W-1:0] RIGHT_SAT = CNT_W'(MAX_RIGHT);

	typedef struct packed {
		logic             clear;
		logic [CNT_W-1:0] num_left;
		logic [CNT_W-1:0] num_right;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_RD,
		ST_CHK,
		ST_SRC,
		ST_ENQ,
		ST_DEQ,
		ST_POP,
		ST_ROW,
		ST_TB_SINK,
		ST_TB_PR,
		ST_TB_LR,
		ST_TB_PL,
		ST_TB_RL,
		ST_DONE
	} state_t;

endpackage

/* src/ibm_bitmat.sv */
// ----------------------------------------------------------------------------
// ibm_bitmat
// Row-wide bit matrix memory, one read and one write port, registered read.
// Rows not written since the last clear read as zero.
// ----------------------------------------------------------------------------
module ibm_bitmat #(
	parameter int ROWS = 256,
	parameter int COLS = 256,
	localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clear,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output logic [COLS-1:0] rdata,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [COLS-1:0] wdata
);

	logic [COLS-1:0] mem [ROWS];
	logic [COLS-1:0] rd_q;
	logic [ROWS-1:0] row_valid_q;
	logic            rd_valid_q;

	// storage array
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	// row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (re) rd_valid_q <= row_valid_q[raddr];
			if (clear) row_valid_q <= '0;
			else if (we) row_valid_q[waddr] <= 1'b1;
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

/* src/ibm_ctrl.sv */
// ----------------------------------------------------------------------------
// ibm_ctrl
// Edge insert, breadth-first search and path reversal sequencer.
// Owns the search queue, parent stores, visited and matched flags.
// ----------------------------------------------------------------------------
module ibm_ctrl import ibm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             start,
	input  logic [IDX_W-1:0] left_index,
	input  logic [IDX_W-1:0] right_index,
	output logic             idle,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [CNT_W-1:0] res_count
);

	state_t state_q, state_d;

	logic [IDX_W-1:0]     u_q, v_q;
	logic [MAX_LEFT-1:0]  mleft_q, vis_l_q, lmask;
	logic [MAX_RIGHT-1:0] mright_q, vis_r_q;
	logic [NMAX-1:0]      cand_q;
	logic                 cand_right_q;
	logic [NIW:0]         par_code_q;
	logic [QAW:0]         head_q, tail_q;
	logic [LW-1:0]        i_q;
	logic [RW-1:0]        j_q;
	logic                 flag_q;
	logic [CNT_W-1:0]     total_q, total_next;

	// row memories
	logic                 lr_re, lr_we, rl_re, rl_we;
	logic [LW-1:0]        lr_raddr, lr_waddr;
	logic [RW-1:0]        rl_raddr, rl_waddr;
	logic [MAX_RIGHT-1:0] lr_rdata, lr_wdata;
	logic [MAX_LEFT-1:0]  rl_rdata, rl_wdata;

	// queue and parent stores
	logic [NIW:0]  queue_mem [QDEPTH];
	logic [NIW:0]  parl_mem [MAX_LEFT];
	logic [LW-1:0] parr_mem [MAX_RIGHT];
	logic [NIW:0]  q_rdata_q, parl_rd_q;
	logic [LW-1:0] parr_rd_q;
	logic          q_we, q_re, parl_we, parr_we, parl_re, parr_re;
	logic [LW-1:0] parl_raddr;
	logic [RW-1:0] parr_raddr;

	// derived terms
	logic [NIW-1:0]       enq_idx;
	logic [LW-1:0]        u_idx, pop_l;
	logic [RW-1:0]        v_idx, pop_r, pj;
	logic                 in_range, dup, pop_right, sink_ok, cand_empty;
	logic [MAX_RIGHT-1:0] bit_v, bit_j;
	logic [MAX_LEFT-1:0]  bit_i;

	function automatic logic [NIW-1:0] low_index(input logic [NMAX-1:0] x);
		logic [NMAX-1:0] low;
		logic [NIW-1:0]  idx;
		low = x & (~x + NMAX'(1));
		idx = '0;
		for (int k = 0; k < NMAX; k++) begin
			if (low[k]) idx = idx | NIW'(k);
		end
		return idx;
	endfunction

	ibm_bitmat #(.ROWS(MAX_LEFT), .COLS(MAX_RIGHT)) u_lr (
		.clk(clk), .arst_n(arst_n), .clear(cfg.clear),
		.re(lr_re), .raddr(lr_raddr), .rdata(lr_rdata),
		.we(lr_we), .waddr(lr_waddr), .wdata(lr_wdata)
	);

	ibm_bitmat #(.ROWS(MAX_RIGHT), .COLS(MAX_LEFT)) u_rl (
		.clk(clk), .arst_n(arst_n), .clear(cfg.clear),
		.re(rl_re), .raddr(rl_raddr), .rdata(rl_rdata),
		.we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata)
	);

	// left nodes in use
	always_comb begin
		for (int k = 0; k < MAX_LEFT; k++) begin
			lmask[k] = (CNT_W'(k) < cfg.num_left);
		end
	end

	// decode helpers
	assign u_idx      = LW'(u_q);
	assign v_idx      = RW'(v_q);
	assign in_range   = (CNT_W'(u_q) < cfg.num_left) && (CNT_W'(v_q) < cfg.num_right);
	assign dup        = lr_rdata[v_idx] | rl_rdata[u_idx];
	assign pop_right  = q_rdata_q[NIW];
	assign pop_l      = LW'(q_rdata_q[NIW-1:0]);
	assign pop_r      = RW'(q_rdata_q[NIW-1:0]);
	assign sink_ok    = (CNT_W'(pop_r) < cfg.num_right) && !mright_q[pop_r];
	assign cand_empty = (cand_q == '0);
	assign enq_idx    = low_index(cand_q);
	assign pj         = RW'(parl_rd_q[NIW-1:0]);
	assign bit_v      = MAX_RIGHT'(1) << v_idx;
	assign bit_j      = MAX_RIGHT'(1) << j_q;
	assign bit_i      = MAX_LEFT'(1) << i_q;
	assign total_next = (flag_q && total_q != COUNT_MAX) ? total_q + CNT_W'(1) : total_q;

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_count = total_next;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (start) state_d = ST_CHK_RD;
			ST_CHK_RD:  state_d = ST_CHK;
			ST_CHK:     state_d = (in_range && !dup) ? ST_SRC : ST_DONE;
			ST_SRC:     state_d = ST_ENQ;
			ST_ENQ:     if (cand_empty) state_d = ST_DEQ;
			ST_DEQ:     state_d = (head_q == tail_q) ? ST_DONE : ST_POP;
			ST_POP:     state_d = (pop_right && sink_ok) ? ST_TB_SINK : ST_ROW;
			ST_ROW:     state_d = ST_ENQ;
			ST_TB_SINK: state_d = ST_TB_PR;
			ST_TB_PR:   state_d = ST_TB_LR;
			ST_TB_LR:   state_d = ST_TB_PL;
			ST_TB_PL:   state_d = parl_rd_q[NIW] ? ST_TB_RL : ST_DONE;
			ST_TB_RL:   state_d = ST_TB_PR;
			ST_DONE:    if (res_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory port requests
	always_comb begin
		lr_re = 1'b0; lr_raddr = '0; lr_we = 1'b0; lr_waddr = '0; lr_wdata = '0;
		rl_re = 1'b0; rl_raddr = '0; rl_we = 1'b0; rl_waddr = '0; rl_wdata = '0;
		q_we = 1'b0; q_re = 1'b0;
		parl_we = 1'b0; parr_we = 1'b0;
		parl_re = 1'b0; parl_raddr = '0;
		parr_re = 1'b0; parr_raddr = '0;
		unique case (state_q)
			ST_CHK_RD: begin
				lr_re = 1'b1; lr_raddr = u_idx;
				rl_re = 1'b1; rl_raddr = v_idx;
			end
			ST_CHK: begin
				lr_we    = in_range && !dup;
				lr_waddr = u_idx;
				lr_wdata = lr_rdata | bit_v;
			end
			ST_ENQ: begin
				q_we    = !cand_empty;
				parr_we = !cand_empty && cand_right_q;
				parl_we = !cand_empty && !cand_right_q;
			end
			ST_DEQ: q_re = (head_q != tail_q);
			ST_POP: begin
				lr_re = !pop_right; lr_raddr = pop_l;
				rl_re = pop_right && !sink_ok; rl_raddr = pop_r;
			end
			ST_TB_SINK: begin
				parr_re = 1'b1; parr_raddr = j_q;
			end
			ST_TB_PR: begin
				lr_re = 1'b1; lr_raddr = parr_rd_q;
				rl_re = 1'b1; rl_raddr = j_q;
			end
			ST_TB_LR: begin
				lr_we = 1'b1; lr_waddr = i_q; lr_wdata = lr_rdata & ~bit_j;
				rl_we = 1'b1; rl_waddr = j_q; rl_wdata = rl_rdata | bit_i;
				parl_re = 1'b1; parl_raddr = i_q;
			end
			ST_TB_PL: begin
				lr_re = parl_rd_q[NIW]; lr_raddr = i_q;
				rl_re = parl_rd_q[NIW]; rl_raddr = pj;
			end
			ST_TB_RL: begin
				lr_we = 1'b1; lr_waddr = i_q; lr_wdata = lr_rdata | bit_j;
				rl_we = 1'b1; rl_waddr = j_q; rl_wdata = rl_rdata & ~bit_i;
				parr_re = 1'b1; parr_raddr = j_q;
			end
			default: ;
		endcase
	end

	// queue and parent stores
	always_ff @(posedge clk) begin
		if (q_we) queue_mem[tail_q[QAW-1:0]] <= {cand_right_q, enq_idx};
		if (q_re) q_rdata_q <= queue_mem[head_q[QAW-1:0]];
		if (parl_we) parl_mem[LW'(enq_idx)] <= par_code_q;
		if (parr_we) parr_mem[RW'(enq_idx)] <= LW'(par_code_q[NIW-1:0]);
		if (parl_re) parl_rd_q <= parl_mem[parl_raddr];
		if (parr_re) parr_rd_q <= parr_mem[parr_raddr];
	end

	// working registers without reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				u_q <= left_index;
				v_q <= right_index;
			end
			ST_SRC: begin
				cand_q       <= NMAX'(~mleft_q & lmask);
				cand_right_q <= 1'b0;
				par_code_q   <= '0;
			end
			ST_ENQ: cand_q <= cand_q & (cand_q - NMAX'(1));
			ST_POP: begin
				par_code_q   <= q_rdata_q;
				cand_right_q <= !pop_right;
				if (pop_right) j_q <= pop_r;
			end
			ST_ROW: begin
				if (cand_right_q) cand_q <= NMAX'(lr_rdata & ~vis_r_q);
				else cand_q <= NMAX'(rl_rdata & ~vis_l_q);
			end
			ST_TB_PR: i_q <= parr_rd_q;
			ST_TB_PL: if (parl_rd_q[NIW]) j_q <= pj;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mleft_q  <= '0;
			mright_q <= '0;
			vis_l_q  <= '0;
			vis_r_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			flag_q   <= 1'b0;
			total_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.clear) begin
				mleft_q  <= '0;
				mright_q <= '0;
				total_q  <= '0;
			end
			unique case (state_q)
				ST_IDLE: flag_q <= 1'b0;
				ST_CHK: begin
					vis_l_q <= '0;
					vis_r_q <= '0;
					head_q  <= '0;
					tail_q  <= '0;
				end
				ST_ENQ: begin
					if (!cand_empty) begin
						tail_q <= tail_q + (QAW+1)'(1);
						if (cand_right_q) vis_r_q[RW'(enq_idx)] <= 1'b1;
						else vis_l_q[LW'(enq_idx)] <= 1'b1;
					end
				end
				ST_DEQ: if (head_q != tail_q) head_q <= head_q + (QAW+1)'(1);
				ST_TB_SINK: mright_q[j_q] <= 1'b1;
				ST_TB_LR: if (i_q == u_idx && j_q == v_idx) flag_q <= 1'b1;
				ST_TB_PL: if (!parl_rd_q[NIW]) mleft_q[i_q] <= 1'b1;
				ST_DONE: if (res_ready) total_q <= total_next;
				default: ;
			endcase
		end
	end

endmodule

/* src/incremental_bipartite_matching_top.sv */
// ----------------------------------------------------------------------------
// incremental_bipartite_matching_top
// Incremental maximum bipartite matching over a residual bit matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Registers (APB, byte address 0: num_left, 4: num_right) size the graph;
//   every write clears all edges and the match count. Write only while idle.
//   Input channel: one word holds left_index and right_index, taken when
//   in_valid is high and in_stall low. One item is processed at a time.
//   Output channel: exactly one word per input item carrying matched_count,
//   held in an output register while out_stall is high.
// Flow:
//   duplicate or out-of-range edge: the check read and check lead
//   straight to the output register without a search.
//   new edge: a breadth-first search with one row read per scanned
//   node and one queue write per discovered node, then, when a path is
//   found, a reversal that updates both row memories per left-right pair.
// Reset: clears counts, flags and the graph (both sizes zero).
// A stalled result blocks the next completion but not the next search.
// ----------------------------------------------------------------------------
module incremental_bipartite_matching_top import ibm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [IDX_W-1:0]   left_index,
	input  logic [IDX_W-1:0]   right_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CNT_W-1:0]   matched_count
);

	logic [CNT_W-1:0] num_left_q, num_right_q, wval;
	logic             wr_en, idle, res_valid, slot_free, load;
	logic [CNT_W-1:0] res_count;
	logic             out_valid_q;
	logic [CNT_W-1:0] matched_count_q;
	cfg_t             cfg;

	// register writes
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign wval   = pwdata[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_left_q  <= '0;
			num_right_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_NUM_LEFT:  num_left_q  <= (wval > LEFT_SAT) ? LEFT_SAT : wval;
				REG_NUM_RIGHT: num_right_q <= (wval > RIGHT_SAT) ? RIGHT_SAT : wval;
				default: ;
			endcase
		end
	end

	// register reads
	assign prdata = (paddr[2] == REG_NUM_RIGHT) ? PDATA_W'(num_right_q) : PDATA_W'(num_left_q);

	assign cfg.clear     = wr_en;
	assign cfg.num_left  = num_left_q;
	assign cfg.num_right = num_right_q;

	assign in_stall = !idle;

	ibm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.start(in_valid && idle),
		.left_index(left_index), .right_index(right_index),
		.idle(idle), .res_valid(res_valid), .res_ready(slot_free),
		.res_count(res_count)
	);

	// output register
	assign slot_free = !out_valid_q || !out_stall;
	assign load      = res_valid && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else out_valid_q <= load || (out_valid_q && out_stall);
	end

	always_ff @(posedge clk) begin
		if (load) matched_count_q <= res_count;
	end

	assign out_valid     = out_valid_q;
	assign matched_count = matched_count_q;

endmodule

/* src/ibm_checker.sv */
// ----------------------------------------------------------------------------
// ibm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "incremental_bipartite_matching_top_defines.svh"

module ibm_checker import ibm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [CNT_W-1:0] matched_count
);

	// stalled output word holds
	`IBM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(matched_count))

	// one item at a time: busy right after an accept
	`IBM_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// a matching never exceeds the node count
	`IBM_ASSERT_IMP(a_count_bound, clk, arst_n, out_valid, matched_count <= LEFT_SAT)

endmodule

bind incremental_bipartite_matching_top ibm_checker u_ibm_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.matched_count(matched_count)
);
